// ===== hw/rtl/qtbm_pkg.sv =====
// Shared types, codes, widths and sine tables of the QPSK text bit modulator.
package qtbm_pkg;

  // input func codes
  localparam logic [1:0] FUNC_CHAR = 2'd0;
  localparam logic [1:0] FUNC_SYNC = 2'd1;
  localparam logic [1:0] FUNC_END  = 2'd2;

  // result status codes
  localparam logic [1:0] STATUS_SAMPLE   = 2'd0;
  localparam logic [1:0] STATUS_BAD_CHAR = 2'd1;
  localparam logic [1:0] STATUS_ODD_BITS = 2'd2;

  // register indexes
  localparam logic REG_SAMPLES   = 1'b0;
  localparam logic REG_AMPLITUDE = 1'b1;

  localparam int SPS_W       = 7;
  localparam int AMP_W       = 31;
  localparam int MAG_W       = 15;
  localparam int FRAC_BITS   = 15;
  localparam int PROD_W      = AMP_W + MAG_W;
  localparam int SAMPLE_W    = 32;
  localparam int PHASE_W     = 7;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [SPS_W-1:0]   SPS_RESET       = 7'd30;
  localparam logic [AMP_W-1:0]   AMP_RESET       = 31'h7F00_0000;
  localparam logic [SPS_W-1:0]   MAX_SYMBOL_SAMPLES = 7'd64;
  localparam logic [PHASE_W:0]   PHASE_STEPS     = 8'd72;
  localparam logic [PHASE_W-1:0] PHASE_PER_SAMPLE = 7'd4;
  localparam logic [PHASE_W:0]   QUARTER_STEPS   = 8'd18;

  // command passed from the front to the back through the queue
  typedef struct packed {
    logic       is_err;  // 1: error result, val is the status code
    logic [1:0] val;     // symbol bits b1b0, or status code
  } qtbm_cmd_t;

  // quarter-wave sine, round(32768*sin(k*5 deg)), top entry saturated
  function automatic logic [MAG_W-1:0] quarter_sine(input logic [4:0] k);
    logic [MAG_W-1:0] m;
    unique case (k)
      5'd0:  m = 15'd0;
      5'd1:  m = 15'd2856;
      5'd2:  m = 15'd5690;
      5'd3:  m = 15'd8481;
      5'd4:  m = 15'd11207;
      5'd5:  m = 15'd13848;
      5'd6:  m = 15'd16384;
      5'd7:  m = 15'd18795;
      5'd8:  m = 15'd21063;
      5'd9:  m = 15'd23170;
      5'd10: m = 15'd25102;
      5'd11: m = 15'd26842;
      5'd12: m = 15'd28378;
      5'd13: m = 15'd29698;
      5'd14: m = 15'd30792;
      5'd15: m = 15'd31651;
      5'd16: m = 15'd32270;
      5'd17: m = 15'd32643;
      5'd18: m = 15'd32767;
      default: m = 15'd0;
    endcase
    return m;
  endfunction

  // symbol phase offset in 1/72 carrier period
  function automatic logic [PHASE_W-1:0] symbol_phase(input logic [1:0] sym);
    logic [PHASE_W-1:0] p;
    unique case (sym)
      2'd0: p = 7'd27;
      2'd1: p = 7'd9;
      2'd2: p = 7'd45;
      2'd3: p = 7'd63;
      default: p = 7'd0;
    endcase
    return p;
  endfunction

endpackage

// ===== hw/rtl/qpsk_text_bit_modulator.sv =====
// Top level of the QPSK text bit modulator: config registers, front, queue, back.
//
//  channel   direction  payload                               handshake
//  in_*      input      tdata=char_code[7:0], tuser=func[1:0]  tvalid/tready
//  out_*     output     tdata=sample[31:0], tuser=status[1:0], tvalid/tready
//                       tlast=last
//  cfg_*     input      reg 0 samples_per_symbol @0x0,          APB, pready=1
//                       reg 1 amplitude @0x4
//
//  The front takes one item per cycle while the 4-entry command queue has room.
//  A symbol item yields min(samples_per_symbol, 64) samples at one per cycle;
//  unless the output stalls; the sample sequencer in the back sets that rate.
//  The first sample is issued in its pop cycle, then passes registers s1, s2
//  and s3. Errors yield a single result; items that yield nothing end in the
//  front. A stalled output holds the whole back pipeline; the queue keeps the
//  front going until it fills. Reset is synchronous and clears all control state.
module qpsk_text_bit_modulator (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] char_code
  input  logic [1:0]  in_tuser,   // [1:0] func
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] sample
  output logic [1:0]  out_tuser,  // [1:0] status
  output logic        out_tlast,
  // configuration
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic [qtbm_pkg::SPS_W-1:0] sps_r;
  logic [qtbm_pkg::AMP_W-1:0] amp_r;
  logic cfg_wr;

  logic                in_accept;
  logic                cmd_push;
  qtbm_pkg::qtbm_cmd_t cmd_in;
  qtbm_pkg::qtbm_cmd_t cmd_out;
  logic                q_full, q_empty, q_pop;

  // register file: decode on the word address bit, write on the access phase
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr[2] == qtbm_pkg::REG_AMPLITUDE) ?
                      {1'b0, amp_r} : {25'd0, sps_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sps_r <= qtbm_pkg::SPS_RESET;
      amp_r <= qtbm_pkg::AMP_RESET;
    end else if (cfg_wr) begin
      if (cfg_paddr[2] == qtbm_pkg::REG_AMPLITUDE) begin
        amp_r <= cfg_pwdata[qtbm_pkg::AMP_W-1:0];
      end else begin
        sps_r <= cfg_pwdata[qtbm_pkg::SPS_W-1:0];
      end
    end
  end

  // accept whenever the queue can take a command
  assign in_tready = !q_full;
  assign in_accept = in_tvalid && in_tready;

  qtbm_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept_i (in_accept),
    .func_i   (in_tuser),
    .char_i   (in_tdata),
    .push_o   (cmd_push),
    .cmd_o    (cmd_in)
  );

  qtbm_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_i     (cmd_push),
    .push_cmd_i (cmd_in),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .pop_cmd_o  (cmd_out),
    .empty_o    (q_empty)
  );

  qtbm_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .sps_i        (sps_r),
    .amp_i        (amp_r),
    .q_empty_i    (q_empty),
    .q_cmd_i      (cmd_out),
    .q_pop_o      (q_pop),
    .out_valid_o  (out_tvalid),
    .out_ready_i  (out_tready),
    .out_sample_o (out_tdata),
    .out_status_o (out_tuser),
    .out_last_o   (out_tlast)
  );

  // a command is never pushed into a full queue
  assert property (@(posedge clk) disable iff (!rst_n) cmd_push |-> !q_full)
    else $error("command pushed into full queue");

  // error results are single, zero-valued and close their item
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser != qtbm_pkg::STATUS_SAMPLE) |-> (out_tlast && out_tdata == '0))
    else $error("malformed error result");

  // nothing follows an error transfer: the block stays halted
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && out_tuser != qtbm_pkg::STATUS_SAMPLE) |=> !out_tvalid)
    else $error("result after error");

endmodule

// ===== hw/rtl/qtbm_front.sv =====
// Front end: accept characters, pair bits, queue symbol and error commands.
module qtbm_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept_i,
  input  logic [1:0]        func_i,
  input  logic [7:0]        char_i,
  output logic              push_o,
  output qtbm_pkg::qtbm_cmd_t cmd_o
);

  logic held_bit_r, held_bit_nxt;
  logic waiting_r, waiting_nxt;
  logic toggle_r, toggle_nxt;
  logic halted_r, halted_nxt;
  logic is_space, is_bit;

  assign is_space = (char_i == 8'h20) || (char_i >= 8'h09 && char_i <= 8'h0D);
  assign is_bit   = (char_i == 8'h30) || (char_i == 8'h31);

  always_comb begin
    held_bit_nxt = held_bit_r;
    waiting_nxt  = waiting_r;
    toggle_nxt   = toggle_r;
    halted_nxt   = halted_r;
    push_o       = 1'b0;
    cmd_o        = '0;
    if (accept_i && !halted_r) begin
      unique case (func_i)
        qtbm_pkg::FUNC_SYNC: begin
          push_o     = 1'b1;
          cmd_o.val  = toggle_r ? 2'd3 : 2'd0;
          toggle_nxt = !toggle_r;
        end
        qtbm_pkg::FUNC_END: begin
          if (waiting_r) begin
            push_o       = 1'b1;
            cmd_o.is_err = 1'b1;
            cmd_o.val    = qtbm_pkg::STATUS_ODD_BITS;
            halted_nxt   = 1'b1;
          end
        end
        qtbm_pkg::FUNC_CHAR: begin
          priority if (is_space) begin
            // skip whitespace
          end else if (!is_bit) begin
            push_o       = 1'b1;
            cmd_o.is_err = 1'b1;
            cmd_o.val    = qtbm_pkg::STATUS_BAD_CHAR;
            halted_nxt   = 1'b1;
          end else if (!waiting_r) begin
            held_bit_nxt = char_i[0];
            waiting_nxt  = 1'b1;
          end else begin
            push_o      = 1'b1;
            cmd_o.val   = {held_bit_r, char_i[0]};
            waiting_nxt = 1'b0;
          end
        end
        default: begin
          // unused func code: drop
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_bit_r <= 1'b0;
      waiting_r  <= 1'b0;
      toggle_r   <= 1'b0;
      halted_r   <= 1'b0;
    end else begin
      held_bit_r <= held_bit_nxt;
      waiting_r  <= waiting_nxt;
      toggle_r   <= toggle_nxt;
      halted_r   <= halted_nxt;
    end
  end

endmodule

// ===== hw/rtl/qtbm_fifo.sv =====
// Command queue between the front end and the sample generator.
module qtbm_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push_i,
  input  qtbm_pkg::qtbm_cmd_t push_cmd_i,
  output logic                full_o,
  input  logic                pop_i,
  output qtbm_pkg::qtbm_cmd_t pop_cmd_o,
  output logic                empty_o
);

  qtbm_pkg::qtbm_cmd_t mem_r [qtbm_pkg::QUEUE_DEPTH];
  logic [qtbm_pkg::QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [qtbm_pkg::QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [qtbm_pkg::QPTR_W:0]   count_r, count_nxt;
  logic do_push, do_pop;

  assign full_o    = (count_r == (qtbm_pkg::QPTR_W+1)'(qtbm_pkg::QUEUE_DEPTH));
  assign empty_o   = (count_r == '0);
  assign pop_cmd_o = mem_r[rd_ptr_r];
  assign do_push   = push_i && !full_o;
  assign do_pop    = pop_i && !empty_o;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_cmd_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// ===== hw/rtl/qtbm_back.sv =====
// Back end: expand commands into carrier samples through a three-stage pipeline.
module qtbm_back (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic [qtbm_pkg::SPS_W-1:0]         sps_i,
  input  logic [qtbm_pkg::AMP_W-1:0]         amp_i,
  input  logic                               q_empty_i,
  input  qtbm_pkg::qtbm_cmd_t                q_cmd_i,
  output logic                               q_pop_o,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [qtbm_pkg::SAMPLE_W-1:0]      out_sample_o,
  output logic [1:0]                         out_status_o,
  output logic                               out_last_o
);

  localparam int PW = qtbm_pkg::PHASE_W;

  logic adv;

  // sequencer
  logic          busy_r, busy_nxt;
  logic [1:0]    sym_r, sym_nxt;
  logic [qtbm_pkg::SPS_W-1:0] rem_r, rem_nxt;
  logic [PW-1:0] phase_r, phase_nxt;
  logic [qtbm_pkg::SPS_W-1:0] count;
  logic          iss_v, iss_err, iss_last;
  logic [1:0]    iss_sym, iss_status;
  logic [PW:0]   phase_step;

  // lookup
  logic [PW:0]   idx_raw, idx;
  logic [PW:0]   r_full;
  logic [1:0]    quad;
  logic [4:0]    r;
  logic [qtbm_pkg::MAG_W-1:0] mag_lut;

  // stage registers
  logic          s1_v_r, s2_v_r, s3_v_r;
  logic [qtbm_pkg::MAG_W-1:0] s1_mag_r;
  logic          s1_neg_r, s2_neg_r;
  logic [1:0]    s1_status_r, s2_status_r, s3_status_r;
  logic          s1_last_r, s2_last_r, s3_last_r;
  logic [qtbm_pkg::PROD_W-1:0] s2_prod_r;
  logic [qtbm_pkg::PROD_W-1:0] rounded;
  logic [qtbm_pkg::SAMPLE_W-1:0] mag_ext, s3_sample_r;

  assign adv = !s3_v_r || out_ready_i;

  assign count = (sps_i > qtbm_pkg::MAX_SYMBOL_SAMPLES) ? qtbm_pkg::MAX_SYMBOL_SAMPLES : sps_i;

  always_comb begin
    busy_nxt   = busy_r;
    sym_nxt    = sym_r;
    rem_nxt    = rem_r;
    q_pop_o    = 1'b0;
    iss_v      = 1'b0;
    iss_err    = 1'b0;
    iss_last   = 1'b0;
    iss_sym    = sym_r;
    iss_status = qtbm_pkg::STATUS_SAMPLE;
    if (adv) begin
      if (busy_r) begin
        iss_v    = 1'b1;
        iss_last = (rem_r == 7'd1);
        rem_nxt  = rem_r - 1'b1;
        busy_nxt = (rem_r != 7'd1);
      end else if (!q_empty_i) begin
        q_pop_o = 1'b1;
        if (q_cmd_i.is_err) begin
          iss_v      = 1'b1;
          iss_err    = 1'b1;
          iss_last   = 1'b1;
          iss_status = q_cmd_i.val;
        end else if (count != '0) begin
          // first sample is issued in the pop cycle
          iss_v    = 1'b1;
          iss_sym  = q_cmd_i.val;
          iss_last = (count == 7'd1);
          sym_nxt  = q_cmd_i.val;
          rem_nxt  = count - 1'b1;
          busy_nxt = (count != 7'd1);
        end
      end
    end
  end

  // advance the carrier phase by one sample step, wrap at one carrier period
  assign phase_step = {1'b0, phase_r} + {1'b0, qtbm_pkg::PHASE_PER_SAMPLE};
  always_comb begin
    phase_nxt = phase_r;
    if (iss_v && !iss_err) begin
      phase_nxt = (phase_step >= qtbm_pkg::PHASE_STEPS) ?
                  PW'(phase_step - qtbm_pkg::PHASE_STEPS) : PW'(phase_step);
    end
  end

  // sample index and quarter-wave lookup
  assign idx_raw = {1'b0, phase_r} + {1'b0, qtbm_pkg::symbol_phase(iss_sym)};
  assign idx = (idx_raw >= qtbm_pkg::PHASE_STEPS) ? idx_raw - qtbm_pkg::PHASE_STEPS : idx_raw;

  always_comb begin
    priority if (idx < qtbm_pkg::QUARTER_STEPS) begin
      quad   = 2'd0;
      r_full = idx;
    end else if (idx < 2*qtbm_pkg::QUARTER_STEPS) begin
      quad   = 2'd1;
      r_full = idx - qtbm_pkg::QUARTER_STEPS;
    end else if (idx < 3*qtbm_pkg::QUARTER_STEPS) begin
      quad   = 2'd2;
      r_full = idx - 8'(2*qtbm_pkg::QUARTER_STEPS);
    end else begin
      quad   = 2'd3;
      r_full = idx - 8'(3*qtbm_pkg::QUARTER_STEPS);
    end
  end

  assign r       = quad[0] ? 5'(qtbm_pkg::QUARTER_STEPS - r_full) : r_full[4:0];
  assign mag_lut = qtbm_pkg::quarter_sine(r);

  assign rounded = s2_prod_r + (qtbm_pkg::PROD_W'(1) << (qtbm_pkg::FRAC_BITS - 1));
  assign mag_ext = {1'b0, rounded[qtbm_pkg::FRAC_BITS +: qtbm_pkg::AMP_W]};

  // pipeline payload
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_mag_r    <= iss_err ? '0 : mag_lut;
      s1_neg_r    <= !iss_err && quad[1];
      s1_status_r <= iss_status;
      s1_last_r   <= iss_last;
      s2_prod_r   <= qtbm_pkg::PROD_W'(amp_i) * qtbm_pkg::PROD_W'(s1_mag_r);
      s2_neg_r    <= s1_neg_r;
      s2_status_r <= s1_status_r;
      s2_last_r   <= s1_last_r;
      s3_sample_r <= s2_neg_r ? (~mag_ext + 1'b1) : mag_ext;
      s3_status_r <= s2_status_r;
      s3_last_r   <= s2_last_r;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      sym_r   <= '0;
      rem_r   <= '0;
      phase_r <= '0;
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      s3_v_r  <= 1'b0;
    end else begin
      busy_r  <= busy_nxt;
      sym_r   <= sym_nxt;
      rem_r   <= rem_nxt;
      phase_r <= phase_nxt;
      if (adv) begin
        s1_v_r <= iss_v;
        s2_v_r <= s1_v_r;
        s3_v_r <= s2_v_r;
      end
    end
  end

  assign out_valid_o  = s3_v_r;
  assign out_sample_o = s3_sample_r;
  assign out_status_o = s3_status_r;
  assign out_last_o   = s3_last_r;

endmodule
